// File: hw/rtl/hsa_pkg.sv
// ----------------------------------------------------------------------------
// hsa_pkg
// Shared types and constants for the hinted slot allocator.
// ----------------------------------------------------------------------------
package hsa_pkg;

  localparam int SLOTS_DEF = 1024;
  localparam int WORD_BITS = 32;
  localparam int ACT_FW    = 3;
  localparam int SLOT_FW   = 10;
  localparam int COUNT_FW  = 11;

  localparam logic [ACT_FW-1:0] ACT_ALLOC   = 3'd0;
  localparam logic [ACT_FW-1:0] ACT_MARK    = 3'd1;
  localparam logic [ACT_FW-1:0] ACT_REPLACE = 3'd2;
  localparam logic [ACT_FW-1:0] ACT_CLEAR   = 3'd3;
  localparam logic [ACT_FW-1:0] ACT_LOAD    = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [ACT_FW-1:0]   action;
    logic [SLOT_FW-1:0]  slot;
    logic [COUNT_FW-1:0] count;
  } req_t;

  typedef struct packed {
    logic [SLOT_FW-1:0] slot_id;
    status_t            status;
  } rsp_t;

endpackage

// File: hw/rtl/hinted_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// hinted_slot_allocator_top
// Slot allocator for a growable table with removal flags and a search hint.
// ----------------------------------------------------------------------------
// One request is processed at a time and every request returns one response.
// Removal flags sit in a single-port memory of 32-bit rows, read through a
// registered output; a per-row valid bit makes reset, clear and load take
// effect at once, with no clearing pass. Clear, load, undefined actions and
// out-of-range mark or replace go from acceptance straight to the output state;
// mark and replace read the row, modify and write it back in the evaluate
// state, then respond. Allocate scans the flag rows from the hint, reading one
// row per cycle, up to the first flagged slot or the end of the used range; an
// allocate whose hint is already at the used count goes straight to output.
module hinted_slot_allocator_top
  import hsa_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int BIT_W = $clog2(WORD_BITS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ROWS  = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int XW    = (CNT_W + BIT_W > SLOT_FW) ? CNT_W + BIT_W : SLOT_FW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_OUT
  } state_t;

  state_t               state;
  logic [ACT_FW-1:0]    op;
  logic [CNT_W-1:0]     used_count;
  logic [CNT_W-1:0]     hint;
  logic [ROW_W-1:0]     scan_row;
  logic [BIT_W-1:0]     scan_off;
  rsp_t                 res;
  logic [ROWS-1:0]      row_valid;

  logic [WORD_BITS-1:0] mem [ROWS];
  logic [WORD_BITS-1:0] rd_data;

  logic [XW-1:0]        req_slot_x;
  logic [XW-1:0]        used_x;
  logic [XW-1:0]        hint_x;
  logic [XW-1:0]        cand_x;
  logic [XW-1:0]        next_x;
  logic [ROW_W-1:0]     req_row;
  logic [ROW_W-1:0]     hint_row;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] hits;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] wdata;
  logic [BIT_W-1:0]     pos;
  logic                 found;
  logic                 more;
  logic                 used_full;
  logic                 load_sat;
  logic [CNT_W-1:0]     load_cnt;
  logic                 mem_re;
  logic                 mem_we;
  logic [ROW_W-1:0]     mem_raddr;

  assign req_stall  = (state != S_IDLE);
  assign req_slot_x = XW'(req.slot);
  assign used_x     = XW'(used_count);
  assign hint_x     = XW'(hint);
  assign req_row    = ROW_W'(req_slot_x >> BIT_W);
  assign hint_row   = ROW_W'(hint_x >> BIT_W);
  assign used_full  = (used_x >= XW'(SLOTS));
  assign load_sat   = (32'(req.count) > 32'(SLOTS));
  assign load_cnt   = load_sat ? CNT_W'(SLOTS) : CNT_W'(req.count);

  assign word     = row_valid[scan_row] ? rd_data : '0;
  assign hits     = word & ({WORD_BITS{1'b1}} << scan_off);
  assign found    = |hits;
  assign bit_mask = WORD_BITS'(1) << scan_off;
  assign cand_x   = (XW'(scan_row) << BIT_W) | XW'(pos);
  assign next_x   = (XW'(scan_row) + XW'(1)) << BIT_W;
  assign more     = (next_x < used_x);

  always_comb begin
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hits[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

  always_comb begin
    wdata = word & ~bit_mask;
    if (op == ACT_MARK) begin
      wdata = word | bit_mask;
    end else if (op == ACT_ALLOC) begin
      wdata = word & ~(WORD_BITS'(1) << pos);
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = req_row;
    if (state == S_IDLE && req_valid) begin
      mem_re    = 1'b1;
      mem_raddr = (req.action == ACT_ALLOC) ? hint_row : req_row;
    end else if (state == S_EVAL && op == ACT_ALLOC && !found && more) begin
      mem_re    = 1'b1;
      mem_raddr = scan_row + ROW_W'(1);
    end
  end

  assign mem_we = (state == S_EVAL) &&
                  ((op == ACT_MARK) || (op == ACT_REPLACE) || (op == ACT_ALLOC && found));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[scan_row] <= wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      hint       <= '0;
      row_valid  <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (state == S_OUT && (!rsp_valid || !rsp_stall)) begin
        rsp       <= res;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op <= req.action;
            if (req.action == ACT_ALLOC) begin
              scan_row <= hint_row;
              scan_off <= BIT_W'(hint_x);
            end else begin
              scan_row <= req_row;
              scan_off <= BIT_W'(req_slot_x);
            end
            unique case (req.action)
              ACT_ALLOC: begin
                if (hint_x < used_x) begin
                  res.status <= ST_OK;
                  state      <= S_EVAL;
                end else if (used_full) begin
                  res.slot_id <= '0;
                  res.status  <= ST_FULL;
                  hint        <= used_count;
                  state       <= S_OUT;
                end else begin
                  res.slot_id <= SLOT_FW'(used_count);
                  res.status  <= ST_OK;
                  used_count  <= used_count + CNT_W'(1);
                  hint        <= used_count + CNT_W'(1);
                  state       <= S_OUT;
                end
              end
              ACT_MARK, ACT_REPLACE: begin
                res.slot_id <= req.slot;
                if (req_slot_x < used_x) begin
                  res.status <= ST_OK;
                  state      <= S_EVAL;
                end else begin
                  res.status <= ST_RANGE;
                  state      <= S_OUT;
                end
              end
              ACT_CLEAR: begin
                res.slot_id <= req.slot;
                res.status  <= ST_OK;
                used_count  <= '0;
                hint        <= '0;
                row_valid   <= '0;
                state       <= S_OUT;
              end
              ACT_LOAD: begin
                res.slot_id <= req.slot;
                used_count  <= load_cnt;
                hint        <= load_cnt;
                row_valid   <= '0;
                state       <= S_OUT;
                if (load_sat) begin
                  res.status <= ST_FULL;
                end else begin
                  res.status <= ST_OK;
                end
              end
              default: begin
                res.slot_id <= req.slot;
                res.status  <= ST_OK;
                state       <= S_OUT;
              end
            endcase
          end
        end
        S_EVAL: begin
          unique case (op)
            ACT_ALLOC: begin
              if (found) begin
                row_valid[scan_row] <= 1'b1;
                res.slot_id         <= SLOT_FW'(cand_x);
                hint                <= CNT_W'(cand_x + XW'(1));
                state               <= S_OUT;
              end else if (more) begin
                scan_row <= scan_row + ROW_W'(1);
                scan_off <= '0;
              end else begin
                state <= S_OUT;
                if (used_full) begin
                  res.slot_id <= '0;
                  res.status  <= ST_FULL;
                  hint        <= used_count;
                end else begin
                  res.slot_id <= SLOT_FW'(used_count);
                  used_count  <= used_count + CNT_W'(1);
                  hint        <= used_count + CNT_W'(1);
                end
              end
            end
            ACT_MARK: begin
              row_valid[scan_row] <= 1'b1;
              hint                <= CNT_W'(res.slot_id);
              state               <= S_OUT;
            end
            ACT_REPLACE: begin
              row_valid[scan_row] <= 1'b1;
              state               <= S_OUT;
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    used_x <= XW'(SLOTS))
    else $error("used count above capacity");

  a_hint_le_count: assert property (@(posedge clk) disable iff (rst)
    hint <= used_count)
    else $error("search hint beyond used count");

  a_grant_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && op == ACT_ALLOC && found) |-> (cand_x < used_x))
    else $error("flagged slot found outside used range");

  a_rsp_after_out: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_OUT))
    else $error("response raised outside output state");
`endif

endmodule

// File: verif/hsa_checker.sv
// ----------------------------------------------------------------------------
// hsa_checker
// Watches both channels of the hinted slot allocator. Predicts the response
// to every accepted request from its own copy of the used count, removal
// flags and search hint, then compares each accepted response, field by field,
// in order. Hands the mismatch count and the number of outstanding responses
// to the testbench top.
// ----------------------------------------------------------------------------
module hsa_checker
  import hsa_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [SLOTS-1:0] flagged;
  int unsigned      used_slots;
  int unsigned      hint;
  rsp_t             grants_due[$];

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors = errors + 1;
  endtask

  function automatic rsp_t grant_for(input req_t r);
    rsp_t        g;
    int unsigned cnt;
    g.slot_id = r.slot;
    g.status  = ST_OK;
    case (r.action)
      ACT_ALLOC: begin
        while (hint < used_slots && !flagged[hint]) hint++;
        if (hint < used_slots) begin
          flagged[hint] = 1'b0;
          g.slot_id     = SLOT_FW'(hint);
          hint++;
        end else if (used_slots >= SLOTS) begin
          hint      = used_slots;
          g.slot_id = '0;
          g.status  = ST_FULL;
        end else begin
          flagged[used_slots] = 1'b0;
          g.slot_id           = SLOT_FW'(used_slots);
          used_slots++;
          hint = used_slots;
        end
      end
      ACT_MARK: begin
        if (r.slot < used_slots) begin
          flagged[r.slot] = 1'b1;
          hint            = r.slot;
        end else begin
          g.status = ST_RANGE;
        end
      end
      ACT_REPLACE: begin
        if (r.slot < used_slots) flagged[r.slot] = 1'b0;
        else g.status = ST_RANGE;
      end
      ACT_CLEAR: begin
        flagged    = '0;
        used_slots = 0;
        hint       = 0;
      end
      ACT_LOAD: begin
        cnt = r.count;
        if (cnt > SLOTS) begin
          cnt      = SLOTS;
          g.status = ST_FULL;
        end
        flagged    = '0;
        used_slots = cnt;
        hint       = cnt;
      end
      default: begin
      end
    endcase
    return g;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      flagged    = '0;
      used_slots = 0;
      hint       = 0;
      errors     = 0;
      grants_due.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (grants_due.size() == 0) begin
          report_mismatch($sformatf("unexpected response slot_id=%0d status=%0d",
                                    rsp.slot_id, rsp.status));
        end else begin
          want = grants_due.pop_front();
          if (rsp.slot_id !== want.slot_id)
            report_mismatch($sformatf("slot_id got %0d want %0d",
                                      rsp.slot_id, want.slot_id));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d (slot_id %0d)",
                                      rsp.status, want.status, want.slot_id));
        end
      end
      if (req_valid && !req_stall) grants_due = {grants_due, grant_for(req)};
    end
    pending <= grants_due.size();
  end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench top for the hinted slot allocator. Drives a directed run over the
// corner cases (empty, full, out-of-range, saturated load, undefined actions)
// and then random request sequences with random idling on both channels;
// the checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
  import hsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS     = SLOTS_DEF;
  localparam int TARGET    = 900;
  localparam int IDLE_MAX  = 4000;
  localparam int TAIL_WAIT = 60;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int   errors;
  int   pending;
  bit   quiet     = 1'b0;
  int   sent      = 0;
  int   span      = 0;
  int   marked    = 0;
  int   idle_cycles = 0;

  always #10 clk = ~clk;

  hinted_slot_allocator_top uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  hsa_checker #(.SLOTS(SLOTS)) chk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    rsp_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 10);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
        $display("timeout: no handshake for %0d cycles", IDLE_MAX);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic issue(input logic [ACT_FW-1:0] act, input int slot_n, input int cnt_n);
    req_t r;
    r.action = act;
    r.slot   = SLOT_FW'(slot_n);
    r.count  = COUNT_FW'(cnt_n);
    if (!quiet && $urandom_range(0, 99) < 10) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    case (act)
      ACT_ALLOC: begin
        if (marked > 0) marked--;
        else if (span < SLOTS) span++;
      end
      ACT_MARK: if (slot_n < span) marked++;
      ACT_CLEAR: begin
        span   = 0;
        marked = 0;
      end
      ACT_LOAD: begin
        span   = (cnt_n > SLOTS) ? SLOTS : cnt_n;
        marked = 0;
      end
      default: begin
      end
    endcase
    if (act <= ACT_LOAD) sent++;
  endtask

  task automatic drain_responses();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic int slot_in_use();
    return (span == 0) ? 0 : $urandom_range(0, span - 1);
  endfunction

  task automatic alloc_burst(input int n);
    repeat (n) issue(ACT_ALLOC, $urandom_range(0, 1023), $urandom_range(0, 2047));
  endtask

  initial begin
    int kind;
    int k;
    int cnt_n;
    int marks[$];
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    issue(ACT_ALLOC, 1023, 2047);
    issue(ACT_MARK, 5, 0);
    issue(ACT_REPLACE, 1023, 0);
    issue(ACT_ALLOC, 0, 0);
    issue(ACT_ALLOC, 0, 0);
    issue(ACT_MARK, 1, 0);
    issue(ACT_ALLOC, 0, 0);
    issue(ACT_LOAD, 0, 2047);
    issue(ACT_ALLOC, 0, 0);
    issue(ACT_MARK, 1023, 0);
    issue(ACT_ALLOC, 0, 0);
    issue(ACT_ALLOC, 0, 0);
    issue(ACT_MARK, 0, 0);
    issue(ACT_REPLACE, 0, 0);
    issue(ACT_ALLOC, 0, 0);
    issue(ACT_MARK, 512, 0);
    issue(ACT_MARK, 3, 0);
    issue(ACT_ALLOC, 0, 0);
    issue(ACT_ALLOC, 0, 0);
    issue(3'd5, 1023, 2047);
    issue(3'd6, 0, 1024);
    issue(3'd7, 341, 682);
    issue(ACT_LOAD, 0, 1024);
    issue(ACT_LOAD, 0, 1025);
    issue(ACT_CLEAR, 682, 1365);
    issue(ACT_LOAD, 0, 0);
    issue(ACT_ALLOC, 0, 0);
    drain_responses();

    sent = 0;
    while (sent < TARGET) begin
      quiet = (sent >= 300 && sent < 450);
      if (sent >= 600 && sent < 610) begin
        drain_responses();
        sent = 610;
      end
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        alloc_burst($urandom_range(1, 8));
      end else if (kind < 55) begin
        k = $urandom_range(1, 4);
        marks.delete();
        repeat (k) begin
          marks = {marks, slot_in_use()};
          issue(ACT_MARK, marks[$], $urandom_range(0, 2047));
        end
        if ($urandom_range(0, 99) < 30)
          issue(ACT_REPLACE, marks[$urandom_range(0, k - 1)], $urandom_range(0, 2047));
        alloc_burst(k);
      end else if (kind < 65) begin
        repeat (2) issue(ACT_REPLACE, slot_in_use(), $urandom_range(0, 2047));
      end else if (kind < 75) begin
        k = $urandom_range(0, 99);
        if (k < 70) cnt_n = $urandom_range(0, 48);
        else if (k < 85) cnt_n = $urandom_range(1000, 1024);
        else cnt_n = $urandom_range(1025, 2047);
        issue(ACT_LOAD, $urandom_range(0, 1023), cnt_n);
        alloc_burst($urandom_range(1, 6));
      end else if (kind < 80) begin
        issue(ACT_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 2047));
        alloc_burst($urandom_range(1, 3));
      end else if (kind < 90) begin
        k = (span < SLOTS) ? $urandom_range(span, SLOTS - 1) : $urandom_range(0, 1023);
        issue($urandom_range(0, 1) ? ACT_MARK : ACT_REPLACE, k, $urandom_range(0, 2047));
      end else begin
        issue(ACT_FW'($urandom_range(0, 7)), $urandom_range(0, 1023),
              $urandom_range(0, 2047));
      end
    end
    quiet = 1'b0;
    drain_responses();
    repeat (TAIL_WAIT) @(posedge clk);

    if (pending != 0) $display("%0d responses never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: hinted_slot_allocator_top.f
hw/rtl/hsa_pkg.sv
hw/rtl/hinted_slot_allocator_top.sv
verif/hsa_checker.sv
verif/tb.sv
